@@ src/lpd_pkg.sv @@
package lpd_pkg;

  // Point index width, set by the 4-bit point number field
  localparam int unsigned PT_W      = 4;
  // Two packet buffers: one filling, one draining
  localparam int unsigned NUM_BANKS = 2;
  localparam int unsigned BANK_W    = 1;
  localparam int unsigned MEM_AW    = BANK_W + PT_W;
  localparam int unsigned MEM_DEPTH = 2 ** MEM_AW;

  localparam logic [7:0]  HDR_BYTE    = 8'h54;
  localparam logic [7:0]  VERLEN_BYTE = 8'h2C;
  localparam logic [16:0] FULL_TURN   = 17'd36000;
  localparam logic [15:0] MAX_ANGLE   = 16'd35999;

  // Byte lane of a point word in the point buffer
  typedef enum logic [1:0] {
    LANE_DIST_LO,
    LANE_DIST_HI,
    LANE_INTENS
  } lane_e;

  // Point buffer write request from the parser
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    lane_e             lane;
    logic [7:0]        data;
  } ram_wr_t;

  // Per-packet descriptor handed from parser to point generator
  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] start;
    logic [15:0] diff;
    logic        sweep;
  } desc_t;

endpackage

@@ src/lpd_front.sv @@
module lpd_front import lpd_pkg::*; #(
  parameter int unsigned POINTS_PER_PACKET = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [BANK_W-1:0] bank_i,
  output ram_wr_t           ram_wr_o,
  output logic              desc_push_o,
  output desc_t             desc_o
);

  localparam int unsigned PKT_LEN = 11 + 3 * POINTS_PER_PACKET;
  localparam int unsigned POS_W   = $clog2(PKT_LEN + 1);

  localparam logic [POS_W-1:0] POS_SPEED_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SPEED_HI = POS_W'(3);
  localparam logic [POS_W-1:0] POS_START_LO = POS_W'(4);
  localparam logic [POS_W-1:0] POS_START_HI = POS_W'(5);
  localparam logic [POS_W-1:0] POS_PT_FIRST = POS_W'(6);
  localparam logic [POS_W-1:0] POS_PT_LAST  = POS_W'(PKT_LEN - 6);
  localparam logic [POS_W-1:0] POS_END_LO   = POS_W'(PKT_LEN - 5);
  localparam logic [POS_W-1:0] POS_END_HI   = POS_W'(PKT_LEN - 4);
  localparam logic [POS_W-1:0] POS_CSUM     = POS_W'(PKT_LEN - 1);
  localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(PKT_LEN);

  typedef enum logic [1:0] {
    F_HUNT,
    F_VERLEN,
    F_PAYLOAD
  } fstate_e;

  fstate_e          state_q;
  logic [POS_W-1:0] pos_q;
  logic [7:0]       sum_q;
  logic [7:0]       lo_q;
  logic [15:0]      speed_q;
  logic [15:0]      start_q;
  logic [15:0]      end_q;
  logic [15:0]      prev_q;
  logic [PT_W-1:0]  pt_q;
  lane_e            lane_q;
  ram_wr_t          ram_wr_q;
  logic             push_q;
  desc_t            desc_q;

  logic [15:0] diff;
  logic [15:0] raw_angle;

  function automatic logic [15:0] clamp_angle(input logic [15:0] a);
    return (a > MAX_ANGLE) ? MAX_ANGLE : a;
  endfunction

  // Angular span of the packet, wrapping through zero
  always_comb begin
    if (end_q >= start_q) begin
      diff = end_q - start_q;
    end else begin
      diff = 16'(({1'b0, end_q} + FULL_TURN) - {1'b0, start_q});
    end
    raw_angle = {rx_byte_i, lo_q};
  end

  // Frame parser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_HUNT;
      pos_q    <= '0;
      sum_q    <= '0;
      lo_q     <= '0;
      speed_q  <= '0;
      start_q  <= '0;
      end_q    <= '0;
      prev_q   <= '0;
      pt_q     <= '0;
      lane_q   <= LANE_DIST_LO;
      ram_wr_q <= '0;
      push_q   <= 1'b0;
      desc_q   <= '0;
    end else begin
      ram_wr_q.en <= 1'b0;
      push_q      <= 1'b0;
      if (accept_i) begin
        unique case (state_q)
          F_VERLEN: begin
            if (rx_byte_i == VERLEN_BYTE) begin
              state_q <= F_PAYLOAD;
              pos_q   <= POS_SPEED_LO;
              sum_q   <= sum_q + rx_byte_i;
              pt_q    <= '0;
              lane_q  <= LANE_DIST_LO;
            end else begin
              state_q <= F_HUNT;
            end
          end
          F_PAYLOAD: begin
            if (pos_q >= POS_LIMIT) begin
              state_q <= F_HUNT;
            end else begin
              pos_q <= pos_q + 1'b1;
              sum_q <= sum_q + rx_byte_i;
              // header fields
              if (pos_q == POS_SPEED_LO) speed_q[7:0]  <= rx_byte_i;
              if (pos_q == POS_SPEED_HI) speed_q[15:8] <= rx_byte_i;
              if (pos_q == POS_START_LO || pos_q == POS_END_LO) lo_q <= rx_byte_i;
              if (pos_q == POS_START_HI) start_q <= clamp_angle(raw_angle);
              if (pos_q == POS_END_HI) end_q <= clamp_angle(raw_angle);
              // point bytes go to the buffer bank being filled
              if (pos_q >= POS_PT_FIRST && pos_q <= POS_PT_LAST) begin
                ram_wr_q.en   <= 1'b1;
                ram_wr_q.addr <= {bank_i, pt_q};
                ram_wr_q.lane <= lane_q;
                ram_wr_q.data <= rx_byte_i;
                case (lane_q)
                  LANE_DIST_LO: lane_q <= LANE_DIST_HI;
                  LANE_DIST_HI: lane_q <= LANE_INTENS;
                  default: begin
                    lane_q <= LANE_DIST_LO;
                    pt_q   <= pt_q + 1'b1;
                  end
                endcase
              end
              // checksum byte closes the packet
              if (pos_q == POS_CSUM) begin
                state_q <= F_HUNT;
                if (sum_q == rx_byte_i) begin
                  push_q       <= 1'b1;
                  desc_q.speed <= speed_q;
                  desc_q.start <= start_q;
                  desc_q.diff  <= diff;
                  desc_q.sweep <= (start_q < prev_q);
                  prev_q       <= start_q;
                end
              end
            end
          end
          default: begin
            if (rx_byte_i == HDR_BYTE) begin
              state_q <= F_VERLEN;
              pos_q   <= POS_W'(1);
              sum_q   <= HDR_BYTE;
            end else begin
              state_q <= F_HUNT;
            end
          end
        endcase
      end
    end
  end

  assign ram_wr_o    = ram_wr_q;
  assign desc_push_o = push_q;
  assign desc_o      = desc_q;

  // payload position never runs past the packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_PAYLOAD) |-> (pos_q < POS_LIMIT))
    else $error("parser position beyond packet length");

endmodule

@@ src/lpd_desc_fifo.sv @@
module lpd_desc_fifo import lpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  desc_t             data_i,
  input  logic              pop_i,
  output desc_t             data_o,
  output logic              valid_o,
  output logic              full_o,
  output logic [BANK_W-1:0] wr_ptr_o,
  output logic [BANK_W-1:0] rd_ptr_o
);

  desc_t             slot_q [NUM_BANKS];
  logic [BANK_W-1:0] wr_q;
  logic [BANK_W-1:0] rd_q;
  logic [BANK_W:0]   cnt_q;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Descriptor storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  assign data_o   = slot_q[rd_q];
  assign valid_o  = (cnt_q != '0);
  assign full_o   = (cnt_q == (BANK_W + 1)'(NUM_BANKS));
  assign wr_ptr_o = wr_q;
  assign rd_ptr_o = rd_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("descriptor queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("descriptor queue underflow");

endmodule

@@ src/lpd_back.sv @@
module lpd_back import lpd_pkg::*; #(
  parameter int unsigned POINTS_PER_PACKET = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ram_wr_t           ram_wr_i,
  input  desc_t             desc_i,
  input  logic              desc_valid_i,
  input  logic [BANK_W-1:0] rd_bank_i,
  output logic              desc_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [15:0]       angle_o,
  output logic [15:0]       distance_o,
  output logic [7:0]        intensity_o,
  output logic [15:0]       speed_o,
  output logic [PT_W-1:0]   point_o,
  output logic              sweep_o,
  output logic              last_o
);

  // angle step numerator diff*i divided by POINTS_PER_PACKET-1 via reciprocal
  localparam int unsigned DIV     = POINTS_PER_PACKET - 1;
  localparam int unsigned NUM_W   = $clog2(36000 * DIV);
  localparam int unsigned SHIFT   = NUM_W;
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / DIV);
  localparam int unsigned PROD_W  = NUM_W + RECIP_W;
  localparam logic [PT_W-1:0]  LAST_IDX = PT_W'(POINTS_PER_PACKET - 1);
  localparam logic [NUM_W-1:0] DIV_N    = NUM_W'(DIV);

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_QUO,
    B_FIX,
    B_OUT
  } bstate_e;

  bstate_e           state_q;
  logic [PT_W-1:0]   idx_q;
  logic [NUM_W-1:0]  num_q;
  logic [PROD_W-1:0] prod_q;
  logic [15:0]       quo_q;
  logic [23:0]       mem_q [MEM_DEPTH];
  logic [23:0]       rdata_q;

  logic [15:0]      q0;
  logic [NUM_W-1:0] rem;
  logic [16:0]      ang_sum;
  logic [15:0]      ang;

  // Point buffer: byte-lane writes from the parser, one registered read
  always_ff @(posedge clk_i) begin
    if (ram_wr_i.en) begin
      case (ram_wr_i.lane)
        LANE_DIST_LO: mem_q[ram_wr_i.addr][7:0]   <= ram_wr_i.data;
        LANE_DIST_HI: mem_q[ram_wr_i.addr][15:8]  <= ram_wr_i.data;
        LANE_INTENS:  mem_q[ram_wr_i.addr][23:16] <= ram_wr_i.data;
        default: ;
      endcase
    end
    rdata_q <= mem_q[{rd_bank_i, idx_q}];
  end

  // Quotient correction and angle wrap
  always_comb begin
    q0      = prod_q[SHIFT +: 16];
    rem     = num_q - NUM_W'(q0 * DIV);
    ang_sum = {1'b0, desc_i.start} + {1'b0, quo_q};
    ang     = (ang_sum >= FULL_TURN) ? 16'(ang_sum - FULL_TURN) : ang_sum[15:0];
  end

  // Point sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      idx_q       <= '0;
      num_q       <= '0;
      prod_q      <= '0;
      quo_q       <= '0;
      angle_o     <= '0;
      distance_o  <= '0;
      intensity_o <= '0;
      speed_o     <= '0;
      point_o     <= '0;
      sweep_o     <= 1'b0;
      last_o      <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (desc_valid_i) begin
            idx_q   <= '0;
            num_q   <= '0;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          prod_q  <= num_q * RECIP;
          state_q <= B_QUO;
        end
        B_QUO: begin
          quo_q   <= q0 + 16'(rem >= DIV_N);
          state_q <= B_FIX;
        end
        B_FIX: begin
          angle_o     <= ang;
          distance_o  <= rdata_q[15:0];
          intensity_o <= rdata_q[23:16];
          speed_o     <= desc_i.speed;
          point_o     <= idx_q;
          sweep_o     <= desc_i.sweep;
          last_o      <= (idx_q == LAST_IDX);
          state_q     <= B_OUT;
        end
        B_OUT: begin
          if (pop_i) begin
            if (idx_q == LAST_IDX) begin
              state_q <= B_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              num_q   <= num_q + NUM_W'(desc_i.diff);
              state_q <= B_MUL;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign empty_o    = (state_q != B_OUT);
  assign desc_pop_o = (state_q == B_OUT) && pop_i && (idx_q == LAST_IDX);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_IDLE) |-> desc_valid_i)
    else $error("point generator busy without a descriptor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_wr_i.en && (state_q != B_IDLE)) |-> (ram_wr_i.addr[MEM_AW-1] != rd_bank_i))
    else $error("parser writes the bank being drained");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_IDLE) |-> (idx_q <= LAST_IDX))
    else $error("point index beyond packet");

endmodule

@@ src/lidar_packet_deframer.sv @@
// A good packet's first point is shown after its descriptor passes the queue and the
// multiply, quotient fix and angle-and-read steps. Bytes are taken at one per cycle while
// not full; each point takes those steps in the shared angle divider, then waits for its pop.
// Two point buffers let the next packet be parsed while one drains.
// Reset (async, active low) puts the parser in hunt, empties the queue and
// clears the previous start angle; no buffer clearing pass is needed.
module lidar_packet_deframer import lpd_pkg::*; #(
  parameter int unsigned POINTS_PER_PACKET = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      rx_byte_i,
  output logic            empty,
  input  logic            pop,
  output logic [15:0]     angle_centideg_o,
  output logic [15:0]     distance_mm_o,
  output logic [7:0]      intensity_o,
  output logic [15:0]     rotation_speed_o,
  output logic [PT_W-1:0] point_number_o,
  output logic            sweep_start_o,
  output logic            last_point_o
);

  logic              accept;
  ram_wr_t           ram_wr;
  logic              desc_push;
  desc_t             desc_in;
  desc_t             desc_head;
  logic              desc_valid;
  logic              desc_full;
  logic              desc_pop;
  logic [BANK_W-1:0] wr_bank;
  logic [BANK_W-1:0] rd_bank;

  // Input request taken unless both point buffers are in use
  assign full   = desc_full;
  assign accept = push && !desc_full;

  lpd_front #(
    .POINTS_PER_PACKET(POINTS_PER_PACKET)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .bank_i     (wr_bank),
    .ram_wr_o   (ram_wr),
    .desc_push_o(desc_push),
    .desc_o     (desc_in)
  );

  lpd_desc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .data_i  (desc_in),
    .pop_i   (desc_pop),
    .data_o  (desc_head),
    .valid_o (desc_valid),
    .full_o  (desc_full),
    .wr_ptr_o(wr_bank),
    .rd_ptr_o(rd_bank)
  );

  lpd_back #(
    .POINTS_PER_PACKET(POINTS_PER_PACKET)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ram_wr_i    (ram_wr),
    .desc_i      (desc_head),
    .desc_valid_i(desc_valid),
    .rd_bank_i   (rd_bank),
    .desc_pop_o  (desc_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .angle_o     (angle_centideg_o),
    .distance_o  (distance_mm_o),
    .intensity_o (intensity_o),
    .speed_o     (rotation_speed_o),
    .point_o     (point_number_o),
    .sweep_o     (sweep_start_o),
    .last_o      (last_point_o)
  );

endmodule

@@ sim/testbench.sv @@
module testbench;
  import lpd_pkg::*;

  localparam int unsigned NPTS    = 12;
  localparam int unsigned PKT_LEN = 11 + 3 * NPTS;

  // Parser phases of the local predictor
  typedef enum logic [1:0] {
    SEEK_HDR,
    SEEK_VERLEN,
    TAKE_BODY
  } seek_e;

  // Point payload patterns for packet building
  typedef enum int {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS,
    FILL_ALTERNATE
  } fill_e;

  typedef struct packed {
    logic [15:0]     angle;
    logic [15:0]     dist_mm;
    logic [7:0]      intens;
    logic [15:0]     speed;
    logic [PT_W-1:0] idx;
    logic            sweep;
    logic            last;
  } point_t;

  logic            clk_i;
  logic            rst_ni;
  logic            push      = 1'b0;
  logic            full;
  logic [7:0]      rx_byte_i = 8'h00;
  logic            empty;
  logic            pop       = 1'b0;
  logic [15:0]     angle_centideg_o;
  logic [15:0]     distance_mm_o;
  logic [7:0]      intensity_o;
  logic [15:0]     rotation_speed_o;
  logic [PT_W-1:0] point_number_o;
  logic            sweep_start_o;
  logic            last_point_o;

  // Byte stream waiting to be pushed, and points the block still owes
  logic [7:0] rx_backlog[$];
  point_t     pending_points[$];

  // Predictor state
  seek_e       phase      = SEEK_HDR;
  int unsigned fill_pos   = 0;
  logic [7:0]  pkt_buf[PKT_LEN];
  logic [15:0] prev_start = '0;

  int mismatches = 0;
  int tx_gap     = 0;
  int rx_stall   = 0;
  int tx_calm    = 0;
  int rx_calm    = 0;

  lidar_packet_deframer #(
    .POINTS_PER_PACKET(NPTS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte_i),
    .empty            (empty),
    .pop              (pop),
    .angle_centideg_o (angle_centideg_o),
    .distance_mm_o    (distance_mm_o),
    .intensity_o      (intensity_o),
    .rotation_speed_o (rotation_speed_o),
    .point_number_o   (point_number_o),
    .sweep_start_o    (sweep_start_o),
    .last_point_o     (last_point_o)
  );

  // Gap length: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Clamp a raw packet angle to the valid range
  function automatic int unsigned clamp_angle(logic [15:0] raw);
    return (raw > MAX_ANGLE) ? int'(MAX_ANGLE) : int'(raw);
  endfunction

  // Byte-level deframer prediction; appends the points of a good packet
  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0]  sum;
    int unsigned st;
    int unsigned stop_ang;
    int unsigned diff;
    int unsigned ang;
    int unsigned off;
    logic        sweep;
    point_t      pt;
    case (phase)
      SEEK_VERLEN: begin
        if (b == VERLEN_BYTE) begin
          pkt_buf[1] = b;
          fill_pos   = 2;
          phase      = TAKE_BODY;
        end else begin
          phase = SEEK_HDR;
        end
      end
      TAKE_BODY: begin
        pkt_buf[fill_pos] = b;
        fill_pos++;
        if (fill_pos >= PKT_LEN) begin
          phase = SEEK_HDR;
          sum   = '0;
          for (int k = 0; k < PKT_LEN - 1; k++) sum = sum + pkt_buf[k];
          if (sum == pkt_buf[PKT_LEN-1]) begin
            st       = clamp_angle({pkt_buf[5], pkt_buf[4]});
            stop_ang = clamp_angle({pkt_buf[PKT_LEN-4], pkt_buf[PKT_LEN-5]});
            diff     = (stop_ang >= st) ? stop_ang - st : stop_ang + int'(FULL_TURN) - st;
            sweep    = (st < prev_start);
            prev_start = st[15:0];
            for (int i = 0; i < NPTS; i++) begin
              off = 6 + 3 * i;
              ang = st + (diff * i) / (NPTS - 1);
              if (ang >= FULL_TURN) ang -= FULL_TURN;
              pt.angle   = ang[15:0];
              pt.dist_mm = {pkt_buf[off+1], pkt_buf[off]};
              pt.intens  = pkt_buf[off+2];
              pt.speed   = {pkt_buf[3], pkt_buf[2]};
              pt.idx     = i[PT_W-1:0];
              pt.sweep   = sweep;
              pt.last    = (i == NPTS - 1);
              pending_points.push_back(pt);
            end
          end
        end
      end
      default: begin
        phase = SEEK_HDR;
        if (b == HDR_BYTE) begin
          pkt_buf[0] = b;
          fill_pos   = 1;
          phase      = SEEK_VERLEN;
        end
      end
    endcase
  endfunction

  // Build one framed packet; bad_sum corrupts the checksum byte
  task automatic queue_packet(input logic [15:0] spd, input logic [15:0] a0,
                              input logic [15:0] a1, input fill_e fill,
                              input bit bad_sum);
    logic [7:0]  pk[PKT_LEN];
    logic [7:0]  sum;
    logic [15:0] d;
    logic [7:0]  q;
    pk[0] = HDR_BYTE;
    pk[1] = VERLEN_BYTE;
    pk[2] = spd[7:0];
    pk[3] = spd[15:8];
    pk[4] = a0[7:0];
    pk[5] = a0[15:8];
    for (int i = 0; i < NPTS; i++) begin
      case (fill)
        FILL_ONES: begin
          d = 16'hFFFF;
          q = 8'hFF;
        end
        FILL_ZEROS: begin
          d = '0;
          q = '0;
        end
        FILL_ALTERNATE: begin
          d = (i % 2) ? 16'h0000 : 16'hFFFF;
          q = (i % 2) ? 8'hFF : 8'h00;
        end
        default: begin
          d = 16'($urandom_range(0, 65535));
          q = 8'($urandom_range(0, 255));
        end
      endcase
      pk[6+3*i] = d[7:0];
      pk[7+3*i] = d[15:8];
      pk[8+3*i] = q;
    end
    pk[PKT_LEN-5] = a1[7:0];
    pk[PKT_LEN-4] = a1[15:8];
    pk[PKT_LEN-3] = 8'($urandom_range(0, 255));
    pk[PKT_LEN-2] = 8'($urandom_range(0, 255));
    sum = '0;
    for (int k = 0; k < PKT_LEN - 1; k++) sum = sum + pk[k];
    pk[PKT_LEN-1] = bad_sum ? 8'(sum + $urandom_range(1, 255)) : sum;
    for (int k = 0; k < PKT_LEN; k++) rx_backlog.push_back(pk[k]);
  endtask

  // Random packet angle: mostly in range, sometimes over the clamp limit
  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 9) < 8) return 16'($urandom_range(0, 35999));
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Byte driver: pushes the backlog with random gaps, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      rx_byte_i <= 8'h00;
      tx_gap    <= 0;
    end else begin
      if (push && !full) begin
        deframe_byte(rx_byte_i);
        tx_gap <= pick_gap(tx_calm);
        push   <= 1'b0;
      end else if (!push) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
        end else if (rx_backlog.size() > 0) begin
          push      <= 1'b1;
          rx_byte_i <= rx_backlog.pop_front();
        end
      end
    end
  end

  // Point monitor: pops with random stalls and checks against the prediction
  always @(posedge clk_i or negedge rst_ni) begin
    point_t got;
    point_t want;
    if (!rst_ni) begin
      pop      <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (pop && !empty) begin
        got = '{angle_centideg_o, distance_mm_o, intensity_o, rotation_speed_o,
                point_number_o, sweep_start_o, last_point_o};
        if (pending_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected point ang %0d dist %0d int %0d idx %0d",
                     $time, got.angle, got.dist_mm, got.intens, got.idx);
        end else begin
          want = pending_points.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"%0t: point mismatch, exp ang %0d dist %0d int %0d",
                        " spd %0d idx %0d sw %0b last %0b"},
                       $time, want.angle, want.dist_mm, want.intens, want.speed,
                       want.idx, want.sweep, want.last);
              $display({"%0t:                 got ang %0d dist %0d int %0d",
                        " spd %0d idx %0d sw %0b last %0b"},
                       $time, got.angle, got.dist_mm, got.intens, got.speed,
                       got.idx, got.sweep, got.last);
            end
          end
        end
        rx_stall <= pick_gap(rx_calm);
        pop      <= 1'b0;
      end else if (!pop) begin
        if (rx_stall > 0) rx_stall <= rx_stall - 1;
        else pop <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int good_pk;
    int r;
    int n;
    rst_ni = 1'b0;

    // Directed: noise, a version byte while hunting, a repeated header
    rx_backlog.push_back(8'h00);
    rx_backlog.push_back(8'hFF);
    rx_backlog.push_back(VERLEN_BYTE);
    rx_backlog.push_back(HDR_BYTE);
    rx_backlog.push_back(HDR_BYTE);
    rx_backlog.push_back(VERLEN_BYTE);
    // Full span, field maxima
    queue_packet(16'hFFFF, 16'd0, 16'd35999, FILL_ONES, 1'b0);
    // Angles wrap past a full turn
    queue_packet(16'd3600, 16'd35000, 16'd1000, FILL_ALTERNATE, 1'b0);
    // Start below the previous start: new sweep, zero span
    queue_packet(16'd0, 16'd100, 16'd100, FILL_ZEROS, 1'b0);
    // Raw angles over the limit are clamped
    queue_packet(16'h1234, 16'hFFFF, 16'h9000, FILL_RANDOM, 1'b0);
    // Bad checksum: dropped and previous start kept
    queue_packet(16'h5555, 16'd0, 16'd500, FILL_RANDOM, 1'b1);
    // Largest span, end one below start
    queue_packet(16'hAAAA, 16'd35999, 16'd35998, FILL_RANDOM, 1'b0);
    queue_packet(16'h0001, 16'd1, 16'd0, FILL_RANDOM, 1'b0);

    // Random: mostly well-formed packets, some broken ones and noise
    good_pk = 0;
    while (rx_backlog.size() < 400 || good_pk < 1) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        queue_packet(16'($urandom_range(0, 65535)), rand_angle(), rand_angle(),
                     FILL_RANDOM, 1'b0);
        good_pk++;
      end else if (r < 80) begin
        queue_packet(16'($urandom_range(0, 65535)), rand_angle(), rand_angle(),
                     FILL_RANDOM, 1'b1);
      end else if (r < 87) begin
        // header with a wrong second byte
        rx_backlog.push_back(HDR_BYTE);
        do n = $urandom_range(0, 255); while (n == VERLEN_BYTE);
        rx_backlog.push_back(n[7:0]);
      end else if (r < 93) begin
        // cut-off packet, then header-free filler to resync
        rx_backlog.push_back(HDR_BYTE);
        rx_backlog.push_back(VERLEN_BYTE);
        n = $urandom_range(0, 40);
        repeat (n) rx_backlog.push_back(8'($urandom_range(0, 255)));
        repeat (PKT_LEN + 2) rx_backlog.push_back(8'($urandom_range(0, HDR_BYTE - 1)));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) rx_backlog.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_backlog.size() > 0 || push) @(posedge clk_i);
    while (pending_points.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/lpd_pkg.sv
src/lpd_front.sv
src/lpd_desc_fifo.sv
src/lpd_back.sv
src/lidar_packet_deframer.sv
sim/testbench.sv
